// ----- hw/rtl/elevator_car_dispatcher_defines.svh -----
// Assertion macros shared by the elevator car dispatcher RTL.
`ifndef ELEVATOR_CAR_DISPATCHER_DEFINES_SVH
`define ELEVATOR_CAR_DISPATCHER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ECD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ecd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ECD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ecd assertion failed");

`endif

// ----- hw/rtl/ecd_pkg.sv -----
// Package: types, constants and microcode ROM of the elevator car dispatcher.
package ecd_pkg;

  localparam int NumCars = 4;
  localparam int FloorW  = 8;
  localparam int CarW    = 2;
  localparam int MaskW   = 4;
  localparam int PcW     = 3;
  localparam logic [FloorW-1:0] TopFloorReset = 8'd10;

  typedef enum logic [1:0] {
    ST_ASSIGNED = 2'd0,
    ST_SERVED   = 2'd1,
    ST_REJECTED = 2'd2,
    ST_TICK     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    HEAD_IDLE = 2'd0,
    HEAD_UP   = 2'd1,
    HEAD_DOWN = 2'd2
  } heading_e;

  typedef enum logic [2:0] {
    OP_FETCH,
    OP_NOP,
    OP_SCAN,
    OP_ASSIGN,
    OP_REJECT,
    OP_STEP,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_NO_IN,
    COND_TICK,
    COND_BAD,
    COND_MORE,
    COND_OUT_BUSY
  } cond_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [PcW-1:0]   target;
  } ucode_t;

  typedef struct packed {
    logic in_valid;
    logic tick;
    logic bad;
    logic out_busy;
  } flags_t;

  localparam logic [PcW-1:0] PcFetch  = 3'd0;
  localparam logic [PcW-1:0] PcReject = 3'd5;
  localparam logic [PcW-1:0] PcStep   = 3'd6;
  localparam logic [PcW-1:0] PcScan   = 3'd3;
  localparam logic [PcW-1:0] PcEmit   = 3'd7;

  // Untaken jump falls through to pc + 1; pc wraps from emit back to fetch.
  function automatic ucode_t ucode_rom(logic [PcW-1:0] pc);
    ucode_t w;
    case (pc)
      3'd0:    w = '{op: OP_FETCH,  cond: COND_NO_IN,    target: PcFetch};
      3'd1:    w = '{op: OP_NOP,    cond: COND_TICK,     target: PcStep};
      3'd2:    w = '{op: OP_NOP,    cond: COND_BAD,      target: PcReject};
      3'd3:    w = '{op: OP_SCAN,   cond: COND_MORE,     target: PcScan};
      3'd4:    w = '{op: OP_ASSIGN, cond: COND_ALWAYS,   target: PcEmit};
      3'd5:    w = '{op: OP_REJECT, cond: COND_ALWAYS,   target: PcEmit};
      3'd6:    w = '{op: OP_STEP,   cond: COND_MORE,     target: PcStep};
      3'd7:    w = '{op: OP_EMIT,   cond: COND_OUT_BUSY, target: PcEmit};
      default: w = '{op: OP_FETCH,  cond: COND_NO_IN,    target: PcFetch};
    endcase
    return w;
  endfunction

endpackage

// ----- hw/rtl/ecd_req_if.sv -----
// Interface: request channel (mode, floor) with valid/ready.
interface ecd_req_if
  import ecd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [FloorW-1:0] floor;

  modport source (output valid, mode, floor, input ready);
  modport sink   (input valid, mode, floor, output ready);
endinterface

// ----- hw/rtl/ecd_rsp_if.sv -----
// Interface: result channel with valid/ready.
interface ecd_rsp_if
  import ecd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [CarW-1:0]   car;
  logic [FloorW-1:0] distance;
  logic [MaskW-1:0]  arrived_mask;
  logic [MaskW-1:0]  busy_mask;

  modport source (output valid, status, car, distance, arrived_mask, busy_mask, input ready);
  modport sink   (input valid, status, car, distance, arrived_mask, busy_mask, output ready);
endinterface

// ----- hw/rtl/ecd_sequencer.sv -----
// Microcode sequencer: program counter, ROM lookup, car counter, jumps.
`include "elevator_car_dispatcher_defines.svh"

module ecd_sequencer
  import ecd_pkg::*;
#(
  parameter int NUM_CARS = NumCars,
  localparam int CntW = (NUM_CARS > 1) ? $clog2(NUM_CARS) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  flags_t          flags_i,
  output ucode_t          ctrl_o,
  output logic [CntW-1:0] cnt_o
);

  localparam logic [CntW-1:0] CntLast = CntW'(NUM_CARS - 1);

  logic [PcW-1:0]  pc_q, pc_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  ucode_t          uw;
  logic            more;
  logic            take;

  assign uw   = ucode_rom(pc_q);
  assign more = (cnt_q != CntLast);

  always_comb begin
    case (uw.cond)
      COND_ALWAYS:   take = 1'b1;
      COND_NO_IN:    take = !flags_i.in_valid;
      COND_TICK:     take = flags_i.tick;
      COND_BAD:      take = flags_i.bad;
      COND_MORE:     take = more;
      COND_OUT_BUSY: take = flags_i.out_busy;
      default:       take = 1'b0;
    endcase
  end

  always_comb begin
    pc_d  = take ? uw.target : pc_q + PcW'(1);
    cnt_d = cnt_q;
    case (uw.op)
      OP_FETCH:         cnt_d = '0;
      OP_SCAN, OP_STEP: if (more) cnt_d = cnt_q + CntW'(1);
      default:          cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q  <= PcFetch;
      cnt_q <= '0;
    end else begin
      pc_q  <= pc_d;
      cnt_q <= cnt_d;
    end
  end

  assign ctrl_o = uw;
  assign cnt_o  = cnt_q;

  `ECD_ASSERT_IMP(a_cnt_range, clk_i, rst_ni, 1'b1, cnt_q <= CntLast)
  `ECD_ASSERT_NXT(a_fetch_clears, clk_i, rst_ni, uw.op == OP_FETCH, cnt_q == '0)

endmodule

// ----- hw/rtl/ecd_datapath.sv -----
// Datapath: car registers, nearest-car scan, tick stepping, result register.
`include "elevator_car_dispatcher_defines.svh"

module ecd_datapath
  import ecd_pkg::*;
#(
  parameter int NUM_CARS = NumCars,
  localparam int CntW = (NUM_CARS > 1) ? $clog2(NUM_CARS) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ucode_t            ctrl_i,
  input  logic [CntW-1:0]   cnt_i,
  output flags_t            flags_o,
  input  logic              cfg_we_i,
  input  logic [FloorW-1:0] cfg_wdata_i,
  ecd_req_if.sink           req_i,
  ecd_rsp_if.source         rsp_o
);

  logic [FloorW-1:0] pos_q  [NUM_CARS];
  logic [FloorW-1:0] pos_d  [NUM_CARS];
  logic [FloorW-1:0] goal_q [NUM_CARS];
  logic [FloorW-1:0] goal_d [NUM_CARS];
  heading_e          head_q [NUM_CARS];
  heading_e          head_d [NUM_CARS];

  logic [FloorW-1:0] top_q;
  logic              mode_q, mode_d;
  logic [FloorW-1:0] floor_q, floor_d;
  logic [CntW-1:0]   best_q, best_d;
  logic [FloorW:0]   key_q, key_d;
  logic [FloorW-1:0] bpos_q, bpos_d;
  status_e           st_q, st_d;
  logic [CarW-1:0]   rcar_q, rcar_d;
  logic [FloorW-1:0] rdist_q, rdist_d;
  logic [MaskW-1:0]  arr_q, arr_d;

  logic              ovalid_q, ovalid_d;
  status_e           ost_q;
  logic [CarW-1:0]   ocar_q;
  logic [FloorW-1:0] odist_q;
  logic [MaskW-1:0]  oarr_q, obusy_q;

  logic [FloorW-1:0] cpos, cgoal, cdist, npos;
  heading_e          chead;
  logic [FloorW:0]   ckey;
  logic [MaskW-1:0]  busy;
  logic              accept, emit, any_idle;

  assign cpos  = pos_q[cnt_i];
  assign cgoal = goal_q[cnt_i];
  assign chead = head_q[cnt_i];
  assign cdist = (cpos > floor_q) ? cpos - floor_q : floor_q - cpos;
  assign ckey  = {chead != HEAD_IDLE, cdist};

  always_comb begin
    case (chead)
      HEAD_UP:   npos = cpos + FloorW'(1);
      HEAD_DOWN: npos = cpos - FloorW'(1);
      default:   npos = cpos;
    endcase
  end

  for (genvar i = 0; i < MaskW; i++) begin : g_busy
    if (i < NUM_CARS) begin : g_on
      assign busy[i] = (goal_q[i] != '0);
    end else begin : g_off
      assign busy[i] = 1'b0;
    end
  end

  always_comb begin
    any_idle = 1'b0;
    for (int i = 0; i < NUM_CARS; i++) begin
      if (head_q[i] == HEAD_IDLE) any_idle = 1'b1;
    end
  end

  assign accept = (ctrl_i.op == OP_FETCH) && req_i.valid;
  assign emit   = (ctrl_i.op == OP_EMIT) && (!ovalid_q || rsp_o.ready);

  assign flags_o.in_valid = req_i.valid;
  assign flags_o.tick     = mode_q;
  assign flags_o.bad      = (floor_q == '0) || (floor_q > top_q);
  assign flags_o.out_busy = ovalid_q && !rsp_o.ready;

  always_comb begin
    pos_d   = pos_q;
    goal_d  = goal_q;
    head_d  = head_q;
    mode_d  = mode_q;
    floor_d = floor_q;
    best_d  = best_q;
    key_d   = key_q;
    bpos_d  = bpos_q;
    st_d    = st_q;
    rcar_d  = rcar_q;
    rdist_d = rdist_q;
    arr_d   = arr_q;
    case (ctrl_i.op)
      OP_FETCH: begin
        if (accept) begin
          mode_d  = req_i.mode;
          floor_d = req_i.floor;
          st_d    = ST_TICK;
          rcar_d  = '0;
          rdist_d = '0;
          arr_d   = '0;
        end
      end
      OP_SCAN: begin
        if (cnt_i == '0 || ckey < key_q) begin
          best_d = cnt_i;
          key_d  = ckey;
          bpos_d = cpos;
        end
      end
      OP_ASSIGN: begin
        rcar_d  = CarW'(best_q);
        rdist_d = key_q[FloorW-1:0];
        goal_d[best_q] = floor_q;
        if (floor_q > bpos_q) begin
          head_d[best_q] = HEAD_UP;
          st_d = ST_ASSIGNED;
        end else if (floor_q < bpos_q) begin
          head_d[best_q] = HEAD_DOWN;
          st_d = ST_ASSIGNED;
        end else begin
          goal_d[best_q] = '0;
          head_d[best_q] = HEAD_IDLE;
          st_d = ST_SERVED;
        end
      end
      OP_REJECT: st_d = ST_REJECTED;
      OP_STEP: begin
        if (cgoal == '0) begin
          head_d[cnt_i] = HEAD_IDLE;
        end else begin
          pos_d[cnt_i] = npos;
          if (npos == cgoal) begin
            goal_d[cnt_i] = '0;
            head_d[cnt_i] = HEAD_IDLE;
            for (int i = 0; i < MaskW; i++) begin
              if (int'(cnt_i) == i) arr_d[i] = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (emit) ovalid_d = 1'b1;
    else if (rsp_o.ready) ovalid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CARS; i++) begin
        pos_q[i]  <= FloorW'(1);
        goal_q[i] <= '0;
        head_q[i] <= HEAD_IDLE;
      end
      top_q    <= TopFloorReset;
      ovalid_q <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      goal_q   <= goal_d;
      head_q   <= head_d;
      ovalid_q <= ovalid_d;
      if (cfg_we_i) top_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q  <= mode_d;
    floor_q <= floor_d;
    best_q  <= best_d;
    key_q   <= key_d;
    bpos_q  <= bpos_d;
    st_q    <= st_d;
    rcar_q  <= rcar_d;
    rdist_q <= rdist_d;
    arr_q   <= arr_d;
    if (emit) begin
      ost_q   <= st_q;
      ocar_q  <= rcar_q;
      odist_q <= rdist_q;
      oarr_q  <= arr_q;
      obusy_q <= busy;
    end
  end

  assign req_i.ready        = (ctrl_i.op == OP_FETCH);
  assign rsp_o.valid        = ovalid_q;
  assign rsp_o.status       = ost_q;
  assign rsp_o.car          = ocar_q;
  assign rsp_o.distance     = odist_q;
  assign rsp_o.arrived_mask = oarr_q;
  assign rsp_o.busy_mask    = obusy_q;

  `ECD_ASSERT_IMP(a_rise_on_emit, clk_i, rst_ni, $rose(ovalid_q),
                  $past(ctrl_i.op == OP_EMIT))
  `ECD_ASSERT_IMP(a_idle_first, clk_i, rst_ni, (ctrl_i.op == OP_ASSIGN) && any_idle,
                  !key_q[FloorW])
  `ECD_ASSERT_IMP(a_tick_fields, clk_i, rst_ni, (ctrl_i.op == OP_EMIT) && (st_q == ST_TICK),
                  (rcar_q == '0) && (rdist_q == '0))

endmodule

// ----- hw/rtl/elevator_car_dispatcher.sv -----
// Elevator car dispatcher top level.
//
// Channels: req_i carries one transaction per floor request (mode 0) or time
// tick (mode 1); rsp_o returns exactly one result transaction for each.
// Config: cfg_we_i writes cfg_wdata_i into top_floor (reset 10); write only
// while no transaction is in flight.
// A short microprogram steps a single datapath. Each in-range floor request
// or tick walks the cars one per cycle with a shared compare/step unit; a
// rejected floor (0 or above top_floor) skips the walk. One transaction is
// worked at a time; the next is accepted the cycle after the result is loaded.
// The result sits in an output register; a stalled receiver holds it and
// the sequencer waits in its emit step until the register frees up.
// Reset: every car at floor 1, no goal, idle; top_floor back to 10; the
// sequencer returns to its fetch step with no result pending.
module elevator_car_dispatcher
  import ecd_pkg::*;
#(
  parameter int NUM_CARS = NumCars
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ecd_req_if.sink           req_i,
  ecd_rsp_if.source         rsp_o,
  input  logic              cfg_we_i,
  input  logic [FloorW-1:0] cfg_wdata_i
);

  localparam int CntW = (NUM_CARS > 1) ? $clog2(NUM_CARS) : 1;

  ucode_t          ctrl;
  flags_t          flags;
  logic [CntW-1:0] cnt;

  ecd_sequencer #(
    .NUM_CARS (NUM_CARS)
  ) u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl),
    .cnt_o   (cnt)
  );

  ecd_datapath #(
    .NUM_CARS (NUM_CARS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .cnt_i       (cnt),
    .flags_o     (flags),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .rsp_o       (rsp_o)
  );

endmodule
